[src/owbm_pkg.sv]
`timescale 1ns / 1ps

package owbm_pkg;

   localparam int unsigned TICK_W     = 10;
   localparam int unsigned NUM_REGS   = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam logic [TICK_W-1:0] ONE_EXTRA_TICKS = 10'd15;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RESET_LOW   = 3'd0,
      REG_RESET_SAMPLE = 3'd1,
      REG_RESET_TAIL  = 3'd2,
      REG_START_LOW   = 3'd3,
      REG_WRITE_SLOT  = 3'd4,
      REG_READ_SAMPLE = 3'd5,
      REG_READ_TAIL   = 3'd6,
      REG_BYTE_GAP    = 3'd7
   } reg_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_R_LOW  = 4'd1,
      PH_R_WAIT = 4'd2,
      PH_R_TAIL = 4'd3,
      PH_W_LOW  = 4'd4,
      PH_W_SLOT = 4'd5,
      PH_W_GAP  = 4'd6,
      PH_D_LOW  = 4'd7,
      PH_D_WAIT = 4'd8,
      PH_D_TAIL = 4'd9,
      PH_D_XTRA = 4'd10
   } phase_type;

   localparam logic [TICK_W-1:0] RST_RESET_LOW    = 10'd480;
   localparam logic [TICK_W-1:0] RST_RESET_SAMPLE = 10'd60;
   localparam logic [TICK_W-1:0] RST_RESET_TAIL   = 10'd420;
   localparam logic [TICK_W-1:0] RST_START_LOW    = 10'd1;
   localparam logic [TICK_W-1:0] RST_WRITE_SLOT   = 10'd60;
   localparam logic [TICK_W-1:0] RST_READ_SAMPLE  = 10'd14;
   localparam logic [TICK_W-1:0] RST_READ_TAIL    = 10'd45;
   localparam logic [TICK_W-1:0] RST_BYTE_GAP     = 10'd100;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] tx_byte;
      logic       line_in;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       early_sample;
      logic       late_sample;
      logic [7:0] rx_byte;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low;
      logic [TICK_W-1:0] reset_sample;
      logic [TICK_W-1:0] reset_tail;
      logic [TICK_W-1:0] start_low;
      logic [TICK_W-1:0] write_slot;
      logic [TICK_W-1:0] read_sample;
      logic [TICK_W-1:0] read_tail;
      logic [TICK_W-1:0] byte_gap;
   } cfg_type;

endpackage

[src/owbm_csr.sv]
`timescale 1ns / 1ps

module owbm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owbm_pkg::TICK_W-1:0]     csr_wdata,
   output owbm_pkg::cfg_type               cfg
);
   import owbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx_type'(csr_index))
            REG_RESET_LOW:    cfg_in.reset_low    = csr_wdata;
            REG_RESET_SAMPLE: cfg_in.reset_sample = csr_wdata;
            REG_RESET_TAIL:   cfg_in.reset_tail   = csr_wdata;
            REG_START_LOW:    cfg_in.start_low    = csr_wdata;
            REG_WRITE_SLOT:   cfg_in.write_slot   = csr_wdata;
            REG_READ_SAMPLE:  cfg_in.read_sample  = csr_wdata;
            REG_READ_TAIL:    cfg_in.read_tail    = csr_wdata;
            REG_BYTE_GAP:     cfg_in.byte_gap     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low    <= RST_RESET_LOW;
         cfg_ff.reset_sample <= RST_RESET_SAMPLE;
         cfg_ff.reset_tail   <= RST_RESET_TAIL;
         cfg_ff.start_low    <= RST_START_LOW;
         cfg_ff.write_slot   <= RST_WRITE_SLOT;
         cfg_ff.read_sample  <= RST_READ_SAMPLE;
         cfg_ff.read_tail    <= RST_READ_TAIL;
         cfg_ff.byte_gap     <= RST_BYTE_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/owbm_in_reg.sv]
`timescale 1ns / 1ps

module owbm_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  owbm_pkg::req_type req_data,
   input  logic              advance,
   output logic              hold_valid,
   output owbm_pkg::req_type hold_data
);
   import owbm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   // slot frees up when the held beat moves on
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

[src/owbm_engine.sv]
`timescale 1ns / 1ps

module owbm_engine (
   input  logic              clock,
   input  logic              reset,
   input  owbm_pkg::cfg_type cfg,
   input  logic              step_en,
   input  owbm_pkg::req_type step_data,
   output owbm_pkg::rsp_type step_res
);
   import owbm_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        shift_ff, shift_in;
   logic              first_ff, first_in;
   logic              last_ff, last_in;
   logic [7:0]        rx_ff, rx_in;
   logic [TICK_W-1:0] tick_inc;
   logic [TICK_W-1:0] len;
   logic              done;
   logic              tail_end;
   logic              slot_end;
   op_type            op;

   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   always_comb begin
      unique case (phase_ff)
         PH_R_LOW:            len = at_least_one(cfg.reset_low);
         PH_R_WAIT:           len = at_least_one(cfg.reset_sample);
         PH_R_TAIL:           len = at_least_one(cfg.reset_tail);
         PH_W_LOW, PH_D_LOW:  len = at_least_one(cfg.start_low);
         PH_W_SLOT:           len = at_least_one(cfg.write_slot);
         PH_D_WAIT:           len = at_least_one(cfg.read_sample);
         PH_D_TAIL:           len = at_least_one(cfg.read_tail);
         PH_W_GAP:            len = at_least_one(cfg.byte_gap);
         PH_D_XTRA:           len = ONE_EXTRA_TICKS;
         default:             len = TICK_W'(1);
      endcase
   end

   assign op       = op_type'(step_data.op);
   assign tick_inc = tick_ff + TICK_W'(1);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      first_in = first_ff;
      last_in  = last_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      tail_end = 1'b0;
      slot_end = 1'b0;
      if (op != OP_TICK) begin
         if (phase_ff == PH_IDLE) begin
            tick_in = '0;
            bit_in  = '0;
            unique case (op)
               OP_RESET: phase_in = PH_R_LOW;
               OP_WRITE: begin
                  shift_in = step_data.tx_byte;
                  phase_in = PH_W_LOW;
               end
               OP_READ: begin
                  shift_in = '0;
                  phase_in = PH_D_LOW;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         if (tick_inc >= len) begin
            tick_in = '0;
            unique case (phase_ff)
               PH_R_LOW:  phase_in = PH_R_WAIT;
               PH_R_WAIT: begin
                  first_in = step_data.line_in;
                  phase_in = PH_R_TAIL;
               end
               PH_R_TAIL: begin
                  last_in  = step_data.line_in;
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
               PH_W_LOW:  phase_in = PH_W_SLOT;
               PH_W_SLOT: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  if (bit_ff == 3'd7) begin
                     bit_in = '0;
                     if (cfg.byte_gap == '0) begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_W_GAP;
                     end
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_W_LOW;
                  end
               end
               PH_W_GAP: begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
               PH_D_LOW:  phase_in = PH_D_WAIT;
               PH_D_WAIT: begin
                  shift_in = {step_data.line_in, shift_ff[7:1]};
                  if (cfg.read_tail != '0) begin
                     phase_in = PH_D_TAIL;
                  end else begin
                     tail_end = 1'b1;
                  end
               end
               PH_D_TAIL: tail_end = 1'b1;
               PH_D_XTRA: slot_end = 1'b1;
               default:   phase_in = PH_IDLE;
            endcase
            // a one read back earns the extra recovery ticks
            if (tail_end) begin
               if (shift_in[7]) begin
                  phase_in = PH_D_XTRA;
               end else begin
                  slot_end = 1'b1;
               end
            end
            if (slot_end) begin
               if (bit_ff == 3'd7) begin
                  rx_in    = shift_in;
                  bit_in   = '0;
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_D_LOW;
               end
            end
         end else begin
            tick_in = tick_inc;
         end
      end
   end

   always_comb begin
      step_res.drive_low    = (phase_in == PH_R_LOW) || (phase_in == PH_W_LOW) ||
                              (phase_in == PH_D_LOW) ||
                              ((phase_in == PH_W_SLOT) && !shift_in[0]);
      step_res.busy_res     = (phase_in != PH_IDLE);
      step_res.done_res     = done;
      step_res.early_sample = first_in;
      step_res.late_sample  = last_in;
      step_res.rx_byte      = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         first_ff <= 1'b0;
         last_ff  <= 1'b0;
         rx_ff    <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         rx_ff    <= rx_in;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE)
      else $error("completed operation left the engine busy");

   a_idle_bit_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bit_ff == 3'd0 && tick_ff == '0)
      else $error("idle engine holds a stale bit or tick count");

   a_drive_only_busy: assert property (@(posedge clock) disable iff (reset)
      step_res.drive_low |-> step_res.busy_res)
      else $error("bus pulled low while idle");

   a_hold_without_beat: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(tick_ff) && $stable(shift_ff))
      else $error("engine state moved without a beat");

endmodule

[src/owbm_out_reg.sv]
`timescale 1ns / 1ps

module owbm_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold_valid,
   input  owbm_pkg::rsp_type step_res,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output owbm_pkg::rsp_type rsp_data
);
   import owbm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   assign advance  = !valid_ff || !rsp_stall;
   assign load     = hold_valid && advance;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= step_res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[src/one_wire_bus_master.sv]
`timescale 1ns / 1ps

// 1-wire bus master driven by a stream of beats on the req channel.
// each req beat is one microsecond tick (op tick) or a command: reset,
// write byte or read byte. commands that arrive while busy are dropped.
// every req beat yields exactly one rsp beat with the bus drive level,
// busy and done flags, both presence samples of the last reset and the
// last received byte. line_in is the bus level seen on that beat.
// an accepted req beat first sits in the input register, then the
// phase/counter update lands in the output register as its rsp beat.
// throughput is one beat per cycle while rsp is not stalled; the engine's
// single phase and tick counter update is the only work per beat.
// when rsp is stalled the output register holds its beat and the input
// register keeps one more; req_stall rises only once both are full.
// the csr port is a plain write port; the user must write it only while the
// bus is idle, which the block does not enforce. synchronous reset restores
// the default timings, idles the bus, clears all samples and the received byte.
module one_wire_bus_master (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  owbm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output owbm_pkg::rsp_type               rsp_data,
   input  logic                            csr_write,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owbm_pkg::TICK_W-1:0]     csr_wdata
);
   import owbm_pkg::*;

   cfg_type cfg;
   logic    hold_valid;
   req_type hold_data;
   logic    advance;
   logic    step_en;
   rsp_type step_res;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   assign step_en = hold_valid && advance;

   owbm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (step_en),
      .step_data (hold_data),
      .step_res  (step_res)
   );

   owbm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .step_res   (step_res),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[dv/tb_one_wire_bus_master.sv]
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
   import owbm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned RANDOM_BEATS   = 60;

   typedef logic [TICK_W-1:0] timing_set_type [NUM_REGS];

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_wdata = '0;

   // bus master state as predicted from accepted beats
   phase_type         ow_phase = PH_IDLE;
   logic [TICK_W-1:0] ow_ticks = '0;
   logic [2:0]        ow_bit   = '0;
   logic [7:0]        ow_shift = '0;
   logic              ow_early = 1'b0;
   logic              ow_late  = 1'b0;
   logic [7:0]        ow_rx    = '0;
   timing_set_type    timing = '{RST_RESET_LOW, RST_RESET_SAMPLE, RST_RESET_TAIL,
                                 RST_START_LOW, RST_WRITE_SLOT, RST_READ_SAMPLE,
                                 RST_READ_TAIL, RST_BYTE_GAP};

   rsp_type     expected_q [$];
   rsp_type     want_rsp;
   int unsigned error_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left  = 0;
   int unsigned stall_left = 0;
   bit          idling_on  = 1'b1;

   one_wire_bus_master u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [TICK_W-1:0] min_one(logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   function automatic logic [TICK_W-1:0] phase_length(phase_type p);
      case (p)
         PH_R_LOW:            return min_one(timing[REG_RESET_LOW]);
         PH_R_WAIT:           return min_one(timing[REG_RESET_SAMPLE]);
         PH_R_TAIL:           return min_one(timing[REG_RESET_TAIL]);
         PH_W_LOW, PH_D_LOW:  return min_one(timing[REG_START_LOW]);
         PH_W_SLOT:           return min_one(timing[REG_WRITE_SLOT]);
         PH_D_WAIT:           return min_one(timing[REG_READ_SAMPLE]);
         PH_D_TAIL:           return min_one(timing[REG_READ_TAIL]);
         PH_W_GAP:            return min_one(timing[REG_BYTE_GAP]);
         PH_D_XTRA:           return ONE_EXTRA_TICKS;
         default:             return TICK_W'(1);
      endcase
   endfunction

   function automatic logic close_read_slot();
      if (ow_bit == 3'd7) begin
         ow_rx    = ow_shift;
         ow_bit   = '0;
         ow_phase = PH_IDLE;
         return 1'b1;
      end
      ow_bit   = ow_bit + 1'b1;
      ow_phase = PH_D_LOW;
      return 1'b0;
   endfunction

   function automatic logic after_read_tail();
      if (ow_shift[7]) begin
         ow_phase = PH_D_XTRA;
         return 1'b0;
      end
      return close_read_slot();
   endfunction

   function automatic rsp_type bus_model_step(req_type r);
      rsp_type res;
      logic    done;
      done = 1'b0;
      if (r.op != OP_TICK) begin
         if (ow_phase == PH_IDLE) begin
            ow_ticks = '0;
            ow_bit   = '0;
            case (r.op)
               OP_RESET: ow_phase = PH_R_LOW;
               OP_WRITE: begin
                  ow_shift = r.tx_byte;
                  ow_phase = PH_W_LOW;
               end
               default: begin
                  ow_shift = '0;
                  ow_phase = PH_D_LOW;
               end
            endcase
         end
      end else if (ow_phase != PH_IDLE) begin
         ow_ticks = ow_ticks + 1'b1;
         if (ow_ticks >= phase_length(ow_phase)) begin
            ow_ticks = '0;
            case (ow_phase)
               PH_R_LOW: ow_phase = PH_R_WAIT;
               PH_R_WAIT: begin
                  ow_early = r.line_in;
                  ow_phase = PH_R_TAIL;
               end
               PH_R_TAIL: begin
                  ow_late  = r.line_in;
                  done     = 1'b1;
                  ow_phase = PH_IDLE;
               end
               PH_W_LOW: ow_phase = PH_W_SLOT;
               PH_W_SLOT: begin
                  ow_shift = ow_shift >> 1;
                  if (ow_bit == 3'd7) begin
                     ow_bit = '0;
                     if (timing[REG_BYTE_GAP] == '0) begin
                        done     = 1'b1;
                        ow_phase = PH_IDLE;
                     end else begin
                        ow_phase = PH_W_GAP;
                     end
                  end else begin
                     ow_bit   = ow_bit + 1'b1;
                     ow_phase = PH_W_LOW;
                  end
               end
               PH_W_GAP: begin
                  done     = 1'b1;
                  ow_phase = PH_IDLE;
               end
               PH_D_LOW: ow_phase = PH_D_WAIT;
               PH_D_WAIT: begin
                  ow_shift = {r.line_in, ow_shift[7:1]};
                  if (timing[REG_READ_TAIL] != '0) ow_phase = PH_D_TAIL;
                  else done = after_read_tail();
               end
               PH_D_TAIL: done = after_read_tail();
               PH_D_XTRA: done = close_read_slot();
               default:   ow_phase = PH_IDLE;
            endcase
         end
      end
      res.drive_low    = (ow_phase inside {PH_R_LOW, PH_W_LOW, PH_D_LOW}) ||
                         (ow_phase == PH_W_SLOT && !ow_shift[0]);
      res.busy_res     = (ow_phase != PH_IDLE);
      res.done_res     = done;
      res.early_sample = ow_early;
      res.late_sample  = ow_late;
      res.rx_byte      = ow_rx;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("beat with nothing expected", rsp_data.rx_byte, 8'h00);
         end else begin
            want_rsp = expected_q.pop_front();
            if (rsp_data.drive_low !== want_rsp.drive_low)
               report_mismatch("drive_low", rsp_data.drive_low, want_rsp.drive_low);
            if (rsp_data.busy_res !== want_rsp.busy_res)
               report_mismatch("busy_res", rsp_data.busy_res, want_rsp.busy_res);
            if (rsp_data.done_res !== want_rsp.done_res)
               report_mismatch("done_res", rsp_data.done_res, want_rsp.done_res);
            if (rsp_data.early_sample !== want_rsp.early_sample)
               report_mismatch("early_sample", rsp_data.early_sample,
                               want_rsp.early_sample);
            if (rsp_data.late_sample !== want_rsp.late_sample)
               report_mismatch("late_sample", rsp_data.late_sample, want_rsp.late_sample);
            if (rsp_data.rx_byte !== want_rsp.rx_byte)
               report_mismatch("rx_byte", rsp_data.rx_byte, want_rsp.rx_byte);
         end
      end
   end

   // receiver stalls: a pending long hold-off takes priority over random bursts
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else if (stall_left != 0) begin
         rsp_stall  = 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall = 1'b0;
         if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_beat(op_type op, logic [7:0] tx, logic line);
      req_type r;
      r.op      = op;
      r.tx_byte = tx;
      r.line_in = line;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(bus_model_step(r));
      beats_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_timing(timing_set_type vals);
      wait_drain();
      for (int i = 0; i < NUM_REGS; i++) begin
         @(negedge clock);
         csr_write = 1'b1;
         csr_index = reg_idx_type'(i);
         csr_wdata = vals[i];
         timing[i] = vals[i];
      end
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // line_mode: 0 held low, 1 held high, above 1 random
   task automatic run_op(op_type op, logic [7:0] tx, int line_mode, int noise_pct);
      logic line;
      line = (line_mode > 1) ? 1'($urandom_range(0, 1)) : line_mode[0];
      send_beat(op, tx, line);
      while (ow_phase != PH_IDLE) begin
         line = (line_mode > 1) ? 1'($urandom_range(0, 1)) : line_mode[0];
         if ($urandom_range(0, 99) < noise_pct)
            send_beat(op_type'($urandom_range(1, 3)), 8'($urandom), line);
         else
            send_beat(OP_TICK, 8'($urandom), line);
      end
   endtask

   task automatic test_power_on_defaults();
      repeat (3) send_beat(OP_TICK, 8'hFF, 1'b1);
      send_beat(OP_TICK, 8'h00, 1'b0);
   endtask

   task automatic test_timing_extremes();
      load_timing('{default: '0});
      run_op(OP_RESET, 8'h00, 0, 0);
      run_op(OP_RESET, 8'h00, 1, 0);
      run_op(OP_WRITE, 8'h00, 2, 0);
      run_op(OP_WRITE, 8'hFF, 2, 0);
      run_op(OP_READ, 8'h00, 1, 0);
      run_op(OP_READ, 8'h00, 0, 0);
      load_timing('{default: TICK_W'(1)});
      run_op(OP_RESET, 8'h00, 2, 0);
      run_op(OP_WRITE, 8'h5A, 2, 0);
      run_op(OP_READ, 8'h00, 2, 0);
   endtask

   task automatic test_busy_commands();
      load_timing('{TICK_W'(3), TICK_W'(2), TICK_W'(2), TICK_W'(1), TICK_W'(2),
                    TICK_W'(1), TICK_W'(0), TICK_W'(2)});
      run_op(OP_WRITE, 8'h3C, 2, 50);
      run_op(OP_READ, 8'h00, 2, 50);
      run_op(OP_RESET, 8'h00, 2, 50);
      repeat (4) send_beat(OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic test_backpressure();
      bit saved;
      saved = idling_on;
      idling_on = 1'b0;
      wait_drain();
      hold_left = 300;
      run_op(OP_READ, 8'h00, 2, 0);
      run_op(OP_WRITE, 8'h81, 2, 0);
      wait_drain();
      idling_on = saved;
   endtask

   task automatic test_random_traffic(int unsigned beats_goal, int noise_pct);
      timing_set_type vals;
      int unsigned    goal;
      goal = beats_sent + beats_goal;
      while (beats_sent < goal) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if ($urandom_range(0, 9) == 0) vals[i] = TICK_W'($urandom_range(5, 40));
            else vals[i] = TICK_W'($urandom_range(0, 4));
         end
         load_timing(vals);
         repeat ($urandom_range(3, 8)) begin
            if (beats_sent >= goal) break;
            if ($urandom_range(0, 6) == 0)
               repeat ($urandom_range(1, 4)) send_beat(OP_TICK, 8'($urandom), 1'($urandom));
            else
               run_op(op_type'($urandom_range(1, 3)), 8'($urandom), 2, noise_pct);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_power_on_defaults();
      test_timing_extremes();
      test_busy_commands();
      test_backpressure();
      test_random_traffic(RANDOM_BEATS, 10);
      // last stretch with both sides always ready
      idling_on = 1'b0;
      test_random_traffic(40, 5);
      wait_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
